// ===== src/svpm_pkg.sv =====
`timescale 1ns / 1ps
package svpm_pkg;

    localparam int VOICES_DEF      = 128;
    localparam int NOTES_DEF       = 128;
    localparam int STORE_DEPTH_DEF = 65536;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int LEN_W = 21;

    localparam logic [1:0] MODE_ON   = 2'd0;
    localparam logic [1:0] MODE_OFF  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;
    localparam logic [1:0] MODE_LOAD = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [6:0]         note;
        logic [31:0]        start_time;
        logic [15:0]        sample_addr;
        logic signed [15:0] sample_value;
        logic               block_end;
    } item_t;

    typedef struct packed {
        logic pop;
        logic tick_done;
    } back_stat_t;

endpackage

// ===== src/svpm_if.sv =====
`timescale 1ns / 1ps
interface svpm_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [6:0]         note;
    logic [31:0]        start_time;
    logic [15:0]        sample_addr;
    logic signed [15:0] sample_value;
    logic               block_end;

    modport source (output valid, mode, note, start_time, sample_addr, sample_value,
                    block_end, input ready);
    modport sink (input valid, mode, note, start_time, sample_addr, sample_value,
                  block_end, output ready);
endinterface

interface svpm_mix_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_sample;
    logic               block_end_out;

    modport source (output valid, out_sample, block_end_out, input ready);
    modport sink (input valid, out_sample, block_end_out, output ready);
endinterface

interface svpm_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== src/svpm_front.sv =====
`timescale 1ns / 1ps
module svpm_front #(
    parameter int NOTES = svpm_pkg::NOTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    svpm_cmd_if.sink        cmd,
    input  logic            pop,
    output logic            q_valid,
    output svpm_pkg::item_t q_item
);

    logic [6:0] note_tab [128];
    svpm_pkg::item_t q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    svpm_pkg::item_t in_item;

    // note reduction table, constant
    for (genvar g = 0; g < 128; g++)
    begin : g_note
        assign note_tab[g] = 7'(g % NOTES);
    end

    assign cmd.ready = (cnt_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_item    = q_reg[rp_reg];

    always_comb
    begin
        in_item.mode         = cmd.mode;
        in_item.note         = note_tab[cmd.note];
        in_item.start_time   = cmd.start_time;
        in_item.sample_addr  = cmd.sample_addr;
        in_item.sample_value = cmd.sample_value;
        in_item.block_end    = cmd.block_end;
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/svpm_back.sv =====
`timescale 1ns / 1ps
module svpm_back #(
    parameter int VOICES      = svpm_pkg::VOICES_DEF,
    parameter int STORE_DEPTH = svpm_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = svpm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  svpm_pkg::item_t             q_item,
    input  logic [svpm_pkg::LEN_W-1:0]  sound_len,
    output svpm_pkg::back_stat_t        stat,
    svpm_mix_if.source                  mix
);

    localparam int IW  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int SB  = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
    localparam int CW0 = $clog2(VOICES + 3);
    localparam int CW  = (CW0 > 5) ? CW0 : 5;
    // reciprocal of the store depth, exact for every 16-bit address
    localparam int     RS = 16 + AW;
    localparam longint RM = ((longint'(1) <<< RS) + longint'(STORE_DEPTH) - longint'(1)) /
                            longint'(STORE_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ON   = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          state_reg;
    svpm_pkg::item_t     cur_reg;
    logic [CW-1:0]       cnt_reg;
    logic [33:0]         prod_reg;
    logic [20:0]         rem_reg;
    logic [VOICES-1:0]   valid_reg;
    logic [31:0]         now_reg;
    logic [15:0]         acc_reg;
    logic                p1_vld_reg;
    logic [IW-1:0]       p1_idx_reg;
    logic                p2_vld_reg;
    logic                out_vld_reg;
    logic signed [15:0]  out_sample_reg;
    logic                out_bend_reg;

    logic [38:0]         vmem [VOICES];
    logic [38:0]         vq_reg;
    logic [SB-1:0]       smem [STORE_DEPTH];
    logic signed [SB-1:0] sq_reg;

    logic                pop;
    logic [IW-1:0]       vidx;
    logic                vm_we;
    logic                live;
    logic [31:0]         diff;
    logic                started;
    logic                expired;
    logic                sm_re;
    logic                sm_we;
    logic                retire;
    logic [15:0]         quo;
    logic [20:0]         rem_calc;
    logic signed [15:0]  word_ext;
    logic                out_free;

    assign vidx     = cnt_reg[IW-1:0];
    assign pop      = (state_reg == S_IDLE) && q_valid;
    assign vm_we    = (state_reg == S_ON) && !valid_reg[vidx];
    assign live     = p1_vld_reg && valid_reg[p1_idx_reg];
    assign diff     = now_reg - vq_reg[31:0];
    assign started  = !diff[31];
    assign expired  = diff >= {11'd0, sound_len};
    assign sm_re    = (state_reg == S_SCAN) && live && (cur_reg.mode == svpm_pkg::MODE_TICK)
                      && started && !expired;
    assign sm_we    = (state_reg == S_LOAD) && (cnt_reg == CW'(2));
    assign retire   = (state_reg == S_SCAN) && live &&
                      (((cur_reg.mode == svpm_pkg::MODE_TICK) && started && expired) ||
                       ((cur_reg.mode == svpm_pkg::MODE_OFF) && (vq_reg[38:32] == cur_reg.note)));
    assign quo      = 16'(prod_reg >> RS);
    assign rem_calc = {5'd0, cur_reg.sample_addr} - 21'(quo) * 21'(STORE_DEPTH);
    assign word_ext = 16'(sq_reg);
    assign out_free = !out_vld_reg || mix.ready;

    assign stat.pop       = pop;
    assign stat.tick_done = (state_reg == S_DONE) && out_free;

    assign mix.valid         = out_vld_reg;
    assign mix.out_sample    = out_sample_reg;
    assign mix.block_end_out = out_bend_reg;

    // voice table: note in the top bits, start time below
    always_ff @(posedge clk)
    begin
        if (vm_we)
        begin
            vmem[vidx] <= {cur_reg.note, cur_reg.start_time};
        end
        vq_reg <= vmem[vidx];
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            smem[rem_reg[AW-1:0]] <= cur_reg.sample_value[SB-1:0];
        end
        if (sm_re)
        begin
            sq_reg <= smem[diff[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (vm_we)
            begin
                valid_reg[vidx] <= 1'b1;
            end
            if (retire)
            begin
                valid_reg[p1_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            prod_reg       <= '0;
            rem_reg        <= '0;
            now_reg        <= '0;
            acc_reg        <= '0;
            p1_vld_reg     <= 1'b0;
            p1_idx_reg     <= '0;
            p2_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            out_sample_reg <= '0;
            out_bend_reg   <= 1'b0;
        end
        else
        begin
            if (out_vld_reg && mix.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    acc_reg <= '0;
                    rem_reg <= '0;
                    if (pop)
                    begin
                        case (q_item.mode)
                            svpm_pkg::MODE_ON:   state_reg <= S_ON;
                            svpm_pkg::MODE_LOAD: state_reg <= S_LOAD;
                            default:             state_reg <= S_SCAN;
                        endcase
                    end
                end
                S_ON:
                begin
                    if (vm_we || (cnt_reg == CW'(VOICES - 1)))
                    begin
                        state_reg <= S_IDLE;
                    end
                    cnt_reg <= cnt_reg + CW'(1);
                end
                S_SCAN:
                begin
                    // read, test, accumulate: three voices in flight
                    p1_vld_reg <= (cnt_reg < CW'(VOICES));
                    p1_idx_reg <= vidx;
                    p2_vld_reg <= sm_re;
                    if (p2_vld_reg)
                    begin
                        acc_reg <= acc_reg + 16'(word_ext >>> 1);
                    end
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(VOICES + 1))
                    begin
                        state_reg <= (cur_reg.mode == svpm_pkg::MODE_TICK) ? S_DONE : S_IDLE;
                    end
                end
                S_LOAD:
                begin
                    // multiply by the reciprocal, then take the remainder, then write
                    if (cnt_reg == CW'(0))
                    begin
                        prod_reg <= 34'(cur_reg.sample_addr) * 34'(RM);
                    end
                    if (cnt_reg == CW'(1))
                    begin
                        rem_reg <= rem_calc;
                    end
                    if (cnt_reg == CW'(2))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_vld_reg    <= 1'b1;
                        out_sample_reg <= acc_reg;
                        out_bend_reg   <= cur_reg.block_end;
                        now_reg        <= now_reg + 32'd1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/sample_voice_pool_mixer.sv =====
`timescale 1ns / 1ps
// Polyphonic one-shot sample mixer. Commands enter a two-beat queue and are carried out one
// at a time by a voice engine that walks the voice table one slot per cycle through a
// single-port voice memory. A tick scans every voice and then hands the sample to the
// output register, a note-off scans every voice, a note-on stops its search at the first
// free voice, and a sample load reduces the address modulo the store depth by a reciprocal
// multiply. The queue takes a new beat while the engine works and while a mixed sample
// waits at the output, as long as it is not full. The configuration port is always ready;
// sound_length above the store depth is clamped to it.
module sample_voice_pool_mixer #(
    parameter int VOICES      = svpm_pkg::VOICES_DEF,
    parameter int NOTES       = svpm_pkg::NOTES_DEF,
    parameter int STORE_DEPTH = svpm_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = svpm_pkg::SAMPLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    svpm_cmd_if.sink    cmd,
    svpm_mix_if.source  mix,
    svpm_cfg_if.sink    cfg
);

    logic [svpm_pkg::LEN_W-1:0] len_reg, len_next;
    logic                       q_valid;
    svpm_pkg::item_t            q_item;
    svpm_pkg::back_stat_t       stat;
    logic [svpm_pkg::LEN_W-1:0] cfg_ext;

    assign cfg.ready = 1'b1;
    assign cfg_ext   = {4'd0, cfg.data};
    assign len_next  = (cfg_ext > svpm_pkg::LEN_W'(STORE_DEPTH)) ?
                       svpm_pkg::LEN_W'(STORE_DEPTH) : cfg_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg.valid)
        begin
            len_reg <= len_next;
        end
    end

    svpm_front #(
        .NOTES (NOTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .pop     (stat.pop),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    svpm_back #(
        .VOICES      (VOICES),
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .sound_len (len_reg),
        .stat      (stat),
        .mix       (mix)
    );

`ifndef SYNTHESIS
    a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        stat.pop |-> q_valid)
        else $error("engine took a beat from an empty queue");

    a_out_from_tick : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mix.valid) |-> $past(stat.tick_done))
        else $error("mixed sample raised without a finished tick");

    a_len_clamped : assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= svpm_pkg::LEN_W'(STORE_DEPTH))
        else $error("sound length beyond store depth");
`endif

endmodule
